@@ hw/rtl/frg_pkg.sv @@
// shared types, constants and register codes for the frame rate governor
package frg_pkg;

  localparam int unsigned TimeW      = 32;
  localparam int unsigned FpsW       = 10;
  localparam int unsigned SkipW      = 8;
  localparam int unsigned WaitW      = 31;
  localparam int unsigned StatW      = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 10;
  // widest product: count * 1000 or fps * elapsed
  localparam int unsigned ProdW      = TimeW + FpsW;

  localparam int unsigned MsPerSec   = 1000;
  localparam int unsigned PctScale   = 100;
  localparam int unsigned PctUnpaced = 100;

  localparam logic [FpsW-1:0]  FpsReset     = FpsW'(25);
  localparam logic [SkipW-1:0] MaxSkipReset = SkipW'(2);
  localparam logic [WaitW-1:0] WaitMax      = {WaitW{1'b1}};
  localparam logic [StatW-1:0] StatMax      = {StatW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_FPS = 2'd0,
    REG_MAX_SKIP   = 2'd1
  } cfg_reg_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_CMP  = 8'b0000_0100,
    ST_DIVW = 8'b0000_1000,
    ST_TADD = 8'b0001_0000,
    ST_MEAS = 8'b0010_0000,
    ST_DIVS = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

endpackage

@@ hw/rtl/frg_if.sv @@
// handshake channels of the frame rate governor

interface frg_in_if;
  logic                         valid;
  logic                         ready;
  logic [frg_pkg::TimeW-1:0]    now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

interface frg_out_if;
  logic                         valid;
  logic                         ready;
  logic [frg_pkg::TimeW-1:0]    frame_number;
  logic [frg_pkg::TimeW-1:0]    frame_time_ms;
  logic [frg_pkg::WaitW-1:0]    wait_ms;
  logic                         skip_frame;
  logic                         fps_valid;
  logic [frg_pkg::StatW-1:0]    fps_measured;
  logic [frg_pkg::StatW-1:0]    speed_percent;

  modport source (output valid, output frame_number, output frame_time_ms, output wait_ms,
                  output skip_frame, output fps_valid, output fps_measured,
                  output speed_percent, input ready);
  modport sink   (input valid, input frame_number, input frame_time_ms, input wait_ms,
                  input skip_frame, input fps_valid, input fps_measured,
                  input speed_percent, output ready);
endinterface

interface frg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [frg_pkg::CfgIdxW-1:0]  reg_index;
  logic [frg_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ hw/rtl/frame_rate_governor.sv @@
// frame rate governor: paces frames, skips when behind, reports rate each second
//
//   channel   dir  payload                                            transfer when
//   frame_i   in   now_ms                                             valid && ready
//   result_o  out  frame_number .. speed_percent (one per frame)      valid && ready
//   cfg_i     in   reg_index, wdata (target_fps, max_skip)            valid && ready
//
// a paced frame runs the multiply and compare steps, then one division for the
// wait when ahead and one for the speed on a report; each holds the shared
// 42-step divider; unpaced frames skip pacing, a first frame only opens windows
// reset clears all window state and loads target_fps 25 and max_skip 2
// frame_i is ready only in the idle state; a finished result waits in the
// output register while the next frame is taken, and the next result holds
// in the last step until that register drains
// cfg_i is always ready, and any listed write restarts the windows
module frame_rate_governor (
  input  logic       clk_i,
  input  logic       rst_ni,
  frg_in_if.sink     frame_i,
  frg_out_if.source  result_o,
  frg_cfg_if.sink    cfg_i
);
  import frg_pkg::*;

  // configuration
  logic [FpsW-1:0]  target_fps_q;
  logic [SkipW-1:0] max_skip_q;

  // architectural state
  state_e           state_q;
  logic             started_q;
  logic [TimeW-1:0] frame_counter_q;
  logic [TimeW-1:0] sync_start_q;
  logic [TimeW-1:0] sync_count_q;
  logic [TimeW-1:0] measure_start_q;
  logic [TimeW-1:0] measure_count_q;
  logic [SkipW-1:0] skip_count_q;
  logic [TimeW-1:0] last_time_q;
  logic             out_valid_q;

  // per-frame work registers
  logic [TimeW-1:0] now_q;
  logic [TimeW-1:0] t_q;
  logic [TimeW-1:0] e_q;
  logic [ProdW-1:0] lhs_q;
  logic [ProdW-1:0] rhs_q;
  logic [TimeW-1:0] frame_time_q;
  logic [WaitW-1:0] wait_q;
  logic             fps_valid_q;
  logic [StatW-1:0] measured_q;
  logic [StatW-1:0] speed_q;

  // output payload
  logic [TimeW-1:0] o_frame_number_q;
  logic [TimeW-1:0] o_frame_time_q;
  logic [WaitW-1:0] o_wait_q;
  logic             o_skip_q;
  logic             o_fps_valid_q;
  logic [StatW-1:0] o_measured_q;
  logic [StatW-1:0] o_speed_q;

  logic             in_xfer, out_xfer, cfg_xfer, cfg_hit, out_free;
  logic [TimeW-1:0] meas_elapsed;
  logic             meas_due;
  logic [ProdW-1:0] wait_diff;

  // shared divider
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [ProdW-1:0] div_dividend;
  logic [ProdW-1:0] div_quotient;

  assign frame_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign in_xfer       = frame_i.valid && frame_i.ready;
  assign out_xfer      = out_valid_q && result_o.ready;
  assign cfg_xfer      = cfg_i.valid && cfg_i.ready;
  assign cfg_hit       = cfg_xfer && (cfg_i.reg_index == REG_TARGET_FPS ||
                                      cfg_i.reg_index == REG_MAX_SKIP);
  assign out_free      = !out_valid_q || result_o.ready;

  // measurement window check on the effective time
  assign meas_elapsed = t_q - measure_start_q;
  assign meas_due     = meas_elapsed >= TimeW'(MsPerSec);

  // wait = floor(count*1000/fps) - elapsed, never negative when ahead
  assign wait_diff = div_quotient - ProdW'(e_q);

  // divider is started for the wait when ahead, and for speed on a report
  always_comb begin
    div_start    = 1'b0;
    div_dividend = lhs_q;
    if (state_q == ST_CMP && lhs_q > rhs_q) begin
      div_start = 1'b1;
    end else if (state_q == ST_MEAS && meas_due && target_fps_q != '0) begin
      div_start    = 1'b1;
      div_dividend = ProdW'(measure_count_q) * ProdW'(PctScale);
    end
  end

  frg_div #(
    .DividendW (ProdW),
    .DivisorW  (FpsW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (target_fps_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // sequencer and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_fps_q    <= FpsReset;
      max_skip_q      <= MaxSkipReset;
      state_q         <= ST_IDLE;
      started_q       <= 1'b0;
      frame_counter_q <= '0;
      sync_start_q    <= '0;
      sync_count_q    <= '0;
      measure_start_q <= '0;
      measure_count_q <= '0;
      skip_count_q    <= '0;
      last_time_q     <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            frame_counter_q <= frame_counter_q + 1'b1;
            if (!started_q) begin
              // first frame only opens both windows
              started_q       <= 1'b1;
              sync_start_q    <= frame_i.now_ms;
              measure_start_q <= frame_i.now_ms;
              sync_count_q    <= '0;
              measure_count_q <= '0;
              skip_count_q    <= '0;
              last_time_q     <= frame_i.now_ms;
              state_q         <= ST_DONE;
            end else begin
              measure_count_q <= measure_count_q + 1'b1;
              if (target_fps_q != '0) begin
                sync_count_q <= sync_count_q + 1'b1;
                state_q      <= ST_MUL;
              end else begin
                state_q <= ST_MEAS;
              end
            end
          end
        end
        ST_MUL: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (lhs_q > rhs_q) begin
            skip_count_q <= '0;
            state_q      <= ST_DIVW;
          end else begin
            if (lhs_q == rhs_q || skip_count_q >= max_skip_q) begin
              // on pace, or skipped as far as allowed: restart sync window
              sync_start_q <= t_q;
              sync_count_q <= '0;
              skip_count_q <= '0;
            end else begin
              skip_count_q <= skip_count_q + 1'b1;
            end
            state_q <= ST_MEAS;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            state_q <= ST_TADD;
          end
        end
        ST_TADD: begin
          state_q <= ST_MEAS;
        end
        ST_MEAS: begin
          last_time_q <= t_q;
          if (meas_due) begin
            measure_start_q <= t_q;
            measure_count_q <= '0;
            state_q         <= (target_fps_q != '0) ? ST_DIVS : ST_DONE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DIVS: begin
          if (div_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // user must keep writes to idle (unenforced); a listed write restarts windows
      if (cfg_hit) begin
        if (cfg_i.reg_index == REG_TARGET_FPS) begin
          target_fps_q <= cfg_i.wdata[FpsW-1:0];
        end else begin
          max_skip_q <= cfg_i.wdata[SkipW-1:0];
        end
        started_q       <= 1'b0;
        sync_start_q    <= '0;
        sync_count_q    <= '0;
        measure_start_q <= '0;
        measure_count_q <= '0;
        skip_count_q    <= '0;
      end
    end
  end

  // per-frame datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          now_q        <= frame_i.now_ms;
          t_q          <= frame_i.now_ms;
          e_q          <= frame_i.now_ms - sync_start_q;
          frame_time_q <= started_q ? (frame_i.now_ms - last_time_q) : '0;
          wait_q       <= '0;
          fps_valid_q  <= 1'b0;
          measured_q   <= '0;
          speed_q      <= '0;
        end
      end
      ST_MUL: begin
        // sync count already holds this frame
        lhs_q <= ProdW'(sync_count_q) * ProdW'(MsPerSec);
        rhs_q <= ProdW'(target_fps_q) * ProdW'(e_q);
      end
      ST_DIVW: begin
        if (div_done) begin
          wait_q <= (wait_diff > ProdW'(WaitMax)) ? WaitMax : wait_diff[WaitW-1:0];
        end
      end
      ST_TADD: begin
        // time assumed to advance by exactly the wait
        t_q <= now_q + TimeW'(wait_q);
      end
      ST_MEAS: begin
        if (meas_due) begin
          fps_valid_q <= 1'b1;
          measured_q  <= (measure_count_q > TimeW'(StatMax)) ? StatMax
                                                             : measure_count_q[StatW-1:0];
          speed_q     <= StatW'(PctUnpaced);
        end
      end
      ST_DIVS: begin
        if (div_done) begin
          speed_q <= (div_quotient > ProdW'(StatMax)) ? StatMax : div_quotient[StatW-1:0];
        end
      end
      ST_CMP, ST_DONE: begin
      end
      default: begin
      end
    endcase

    if (state_q == ST_DONE && out_free) begin
      o_frame_number_q <= frame_counter_q;
      o_frame_time_q   <= frame_time_q;
      o_wait_q         <= wait_q;
      o_skip_q         <= (skip_count_q != '0);
      o_fps_valid_q    <= fps_valid_q;
      o_measured_q     <= measured_q;
      o_speed_q        <= speed_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.frame_number  = o_frame_number_q;
  assign result_o.frame_time_ms = o_frame_time_q;
  assign result_o.wait_ms       = o_wait_q;
  assign result_o.skip_frame    = o_skip_q;
  assign result_o.fps_valid     = o_fps_valid_q;
  assign result_o.fps_measured  = o_measured_q;
  assign result_o.speed_percent = o_speed_q;

`ifndef NO_ASSERTIONS
  // a requested wait means the game is ahead, so it never skips that frame
  a_wait_no_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.wait_ms != '0) |-> !result_o.skip_frame)
    else $error("wait requested on a skipped frame");

  // report fields stay zero unless a second completed
  a_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.fps_valid) |->
      (result_o.fps_measured == '0 && result_o.speed_percent == '0))
    else $error("report fields set without a completed measurement");

  // divider is never restarted while it is running
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // a taken frame keeps the input closed for at least the next cycle
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !frame_i.ready)
    else $error("frame taken while the previous one is still in work");
`endif

endmodule

@@ hw/rtl/frg_div.sv @@
// restoring divider, one quotient bit per cycle
module frg_div #(
  parameter int unsigned DividendW = frg_pkg::ProdW,
  parameter int unsigned DivisorW  = frg_pkg::FpsW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o
);
  import frg_pkg::*;

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  dvs_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, done_q;
  logic [DivisorW:0]    shifted, trial;

  // shift in next dividend bit and try the subtract
  assign shifted = {rem_q, quo_q[DividendW-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d = trial[DivisorW] ? shifted[DivisorW-1:0] : trial[DivisorW-1:0];
    quo_d = {quo_q[DividendW-2:0], ~trial[DivisorW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
